[rtl/core/rrs_pkg.sv]
package rrs_pkg;

   // table geometry
   localparam int SLOTS     = 16;
   localparam int RUN_BITS  = 16;
   localparam int WAIT_BITS = 24;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int MEM_W  = RUN_BITS + WAIT_BITS;
   localparam int PROD_W = RUN_BITS + WAIT_BITS;

   // beat field widths
   localparam int JOB_SLOT_W  = 4;
   localparam int BURST_W     = 16;
   localparam int RAN_SLOT_W  = 4;
   localparam int DONE_WAIT_W = 24;

   // request codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [63:0] RUN_MAX_W  = (64'd1 << RUN_BITS) - 64'd1;
   localparam logic [63:0] DONE_MAX_W = (64'd1 << DONE_WAIT_W) - 64'd1;
   localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

   // clamp a burst onto the run-time field
   function automatic logic [RUN_BITS-1:0] sat_run(input logic [BURST_W-1:0] burst);
      logic [63:0] wide;
      wide = 64'(burst);
      if (wide > RUN_MAX_W) begin
         return RUN_BITS'(RUN_MAX_W);
      end
      return RUN_BITS'(wide);
   endfunction

   // clamp a waiting count onto the reported field
   function automatic logic [DONE_WAIT_W-1:0] sat_done(input logic [WAIT_BITS-1:0] wait_val);
      logic [63:0] wide;
      wide = 64'(wait_val);
      if (wide > DONE_MAX_W) begin
         return DONE_WAIT_W'(DONE_MAX_W);
      end
      return DONE_WAIT_W'(wide);
   endfunction

endpackage

[rtl/core/rrs_req_if.sv]
interface rrs_req_if import rrs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [JOB_SLOT_W-1:0] job_slot;
   logic [BURST_W-1:0]    burst_time;

   modport source (output valid, output func, output job_slot, output burst_time,
                   input ready);
   modport sink   (input valid, input func, input job_slot, input burst_time,
                   output ready);
endinterface

[rtl/core/rrs_rsp_if.sv]
interface rrs_rsp_if import rrs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [RAN_SLOT_W-1:0]  ran_slot;
   logic                   busy_res;
   logic                   job_done;
   logic [DONE_WAIT_W-1:0] done_wait;
   logic                   add_error;

   modport source (output valid, output ran_slot, output busy_res, output job_done,
                   output done_wait, output add_error, input ready);
   modport sink   (input valid, input ran_slot, input busy_res, input job_done,
                   input done_wait, input add_error, output ready);
endinterface

[rtl/core/rrs_ram.sv]
module rrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/response_ratio_scheduler_core.sv]
// Add beat: ST_ADD loads or rejects the job into the result registers, then ST_HOLD moves the
//   result to the output register once it is free and the next beat is taken in ST_IDLE.
// Tick beat: one RAM sweep in ST_SCAN (one slot read and compared per cycle through a single
//   cross-multiply comparator), then ST_FIN and ST_HOLD, which holds the result until the output register is free.
// Reset (synchronous, active high) clears the active marks, the pending masks and the
//   control state; the slot RAM is not cleared and needs no clearing pass.
module response_ratio_scheduler_core import rrs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rrs_req_if.sink   req_bus,
   rrs_rsp_if.source rsp_bus
);

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADD  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_HOLD = 3'd4;

   localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);

   logic [2:0]             state_ff, state_in;

   // captured request beat
   logic [JOB_SLOT_W-1:0]  cap_slot_ff, cap_slot_in;
   logic [BURST_W-1:0]     cap_burst_ff, cap_burst_in;

   // sweep pipeline: read issue counter and the slot whose data is on the RAM output
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [SLOT_W-1:0]      proc_idx_ff, proc_idx_in;

   // best candidate so far
   logic                   best_valid_ff, best_valid_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic [WAIT_BITS-1:0]   best_w_ff, best_w_in;
   logic [RUN_BITS-1:0]    best_r_ff, best_r_in;

   // slot marks and the updates of the last tick, applied lazily on the next sweep
   logic [SLOTS-1:0]       active_ff, active_in;
   logic [SLOTS-1:0]       pend_wait_ff, pend_wait_in;
   logic                   pend_dec_ff, pend_dec_in;
   logic [SLOT_W-1:0]      pend_idx_ff, pend_idx_in;

   // finished result, waiting for the output register
   logic [RAN_SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic                   res_busy_ff, res_busy_in;
   logic                   res_done_ff, res_done_in;
   logic [DONE_WAIT_W-1:0] res_wait_ff, res_wait_in;
   logic                   res_err_ff, res_err_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RAN_SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                   rsp_busy_ff, rsp_busy_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [DONE_WAIT_W-1:0] rsp_wait_ff, rsp_wait_in;
   logic                   rsp_err_ff, rsp_err_in;

   // slot RAM: {wait, remaining}
   logic                   ram_wr_en;
   logic [SLOT_W-1:0]      ram_wr_addr;
   logic [MEM_W-1:0]       ram_wr_data;
   logic                   ram_rd_en;
   logic [SLOT_W-1:0]      ram_rd_addr;
   logic [MEM_W-1:0]       ram_rd_data;

   logic [WAIT_BITS-1:0]   cur_w, upd_w;
   logic [RUN_BITS-1:0]    cur_r, upd_r;
   logic [PROD_W-1:0]      lhs, rhs;
   logic                   take;
   logic                   fin_done;
   logic                   add_err;
   logic [SLOT_W-1:0]      add_idx;
   logic                   req_hs;
   logic                   rsp_free;

   rrs_ram #(
      .WIDTH (MEM_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_hs            = req_bus.valid && req_bus.ready;
   assign rsp_free          = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.ran_slot  = rsp_slot_ff;
   assign rsp_bus.busy_res  = rsp_busy_ff;
   assign rsp_bus.job_done  = rsp_done_ff;
   assign rsp_bus.done_wait = rsp_wait_ff;
   assign rsp_bus.add_error = rsp_err_ff;

   // issue one read per sweep cycle
   assign ram_rd_en   = (state_ff == ST_SCAN) && (cnt_ff < CNT_SLOTS);
   assign ram_rd_addr = SLOT_W'(cnt_ff);

   // apply last tick's pending updates to the slot on the RAM output
   assign cur_w = ram_rd_data[MEM_W-1:RUN_BITS];
   assign cur_r = ram_rd_data[RUN_BITS-1:0];
   assign upd_w = (pend_wait_ff[proc_idx_ff] && (cur_w != WAIT_MAX))
                  ? cur_w + WAIT_BITS'(1) : cur_w;
   assign upd_r = (pend_dec_ff && (proc_idx_ff == pend_idx_ff))
                  ? cur_r - RUN_BITS'(1) : cur_r;

   // exact ratio compare: w_i * r_best against w_best * r_i; strict, so ties keep the lower slot
   assign lhs  = PROD_W'(upd_w) * PROD_W'(best_r_ff);
   assign rhs  = PROD_W'(best_w_ff) * PROD_W'(upd_r);
   assign take = proc_valid_ff && active_ff[proc_idx_ff] && (!best_valid_ff || (lhs > rhs));

   assign fin_done = best_valid_ff && (best_r_ff == RUN_BITS'(1));

   assign add_idx = SLOT_W'(cap_slot_ff);
   assign add_err = (32'(cap_slot_ff) >= SLOTS) || (cap_burst_ff == '0)
                    || active_ff[add_idx];

   always_comb begin
      state_in      = state_ff;
      cap_slot_in   = cap_slot_ff;
      cap_burst_in  = cap_burst_ff;
      cnt_in        = cnt_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = proc_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_w_in     = best_w_ff;
      best_r_in     = best_r_ff;
      active_in     = active_ff;
      pend_wait_in  = pend_wait_ff;
      pend_dec_in   = pend_dec_ff;
      pend_idx_in   = pend_idx_ff;
      res_slot_in   = res_slot_ff;
      res_busy_in   = res_busy_ff;
      res_done_in   = res_done_ff;
      res_wait_in   = res_wait_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_err_in    = rsp_err_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = proc_idx_ff;
      ram_wr_data   = {upd_w, upd_r};

      case (state_ff)
         ST_IDLE: begin
            // take the beat and decode it
            if (req_hs) begin
               cap_slot_in   = req_bus.job_slot;
               cap_burst_in  = req_bus.burst_time;
               cnt_in        = '0;
               best_valid_in = 1'b0;
               state_in      = (req_bus.func == FUNC_TICK) ? ST_SCAN : ST_ADD;
            end
         end
         ST_ADD: begin
            // load a fresh job, or reject it and leave the table as it is
            if (!add_err) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = add_idx;
               ram_wr_data        = {WAIT_BITS'(0), sat_run(cap_burst_ff)};
               active_in[add_idx] = 1'b1;
            end
            res_slot_in = '0;
            res_busy_in = 1'b0;
            res_done_in = 1'b0;
            res_wait_in = '0;
            res_err_in  = add_err;
            state_in    = ST_HOLD;
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               cnt_in        = cnt_ff + CNT_W'(1);
               proc_valid_in = 1'b1;
               proc_idx_in   = SLOT_W'(cnt_ff);
            end
            // write back the brought-up-to-date slot and compare it
            if (proc_valid_ff && active_ff[proc_idx_ff]) begin
               ram_wr_en = 1'b1;
            end
            if (take) begin
               best_valid_in = 1'b1;
               best_idx_in   = proc_idx_ff;
               best_w_in     = upd_w;
               best_r_in     = upd_r;
            end
            if (cnt_ff == CNT_SLOTS) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // run the pick: others wait, the pick loses one unit on the next sweep
            res_err_in = 1'b0;
            if (best_valid_ff) begin
               res_slot_in  = RAN_SLOT_W'(best_idx_ff);
               res_busy_in  = 1'b1;
               res_done_in  = fin_done;
               res_wait_in  = fin_done ? sat_done(best_w_ff) : '0;
               pend_wait_in = active_ff & ~(SLOTS'(1) << best_idx_ff);
               pend_dec_in  = !fin_done;
               pend_idx_in  = best_idx_ff;
               if (fin_done) begin
                  active_in[best_idx_ff] = 1'b0;
               end
            end else begin
               res_slot_in  = '0;
               res_busy_in  = 1'b0;
               res_done_in  = 1'b0;
               res_wait_in  = '0;
               pend_wait_in = '0;
               pend_dec_in  = 1'b0;
            end
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // hold the result until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_busy_in  = res_busy_ff;
               rsp_done_in  = res_done_ff;
               rsp_wait_in  = res_wait_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         proc_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         active_ff     <= '0;
         pend_wait_ff  <= '0;
         pend_dec_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         proc_valid_ff <= proc_valid_in;
         best_valid_ff <= best_valid_in;
         active_ff     <= active_in;
         pend_wait_ff  <= pend_wait_in;
         pend_dec_ff   <= pend_dec_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_slot_ff  <= cap_slot_in;
      cap_burst_ff <= cap_burst_in;
      proc_idx_ff  <= proc_idx_in;
      best_idx_ff  <= best_idx_in;
      best_w_ff    <= best_w_in;
      best_r_ff    <= best_r_in;
      pend_idx_ff  <= pend_idx_in;
      res_slot_ff  <= res_slot_in;
      res_busy_ff  <= res_busy_in;
      res_done_ff  <= res_done_in;
      res_wait_ff  <= res_wait_in;
      res_err_ff   <= res_err_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_busy_ff  <= rsp_busy_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // pending wait credit only ever covers live jobs
   assert property (@(posedge clock) disable iff (reset)
      (pend_wait_ff & ~active_ff) == '0)
      else $error("pending wait credit on an inactive slot");

   // the deferred run decrement targets a live job
   assert property (@(posedge clock) disable iff (reset)
      pend_dec_ff |-> active_ff[pend_idx_ff])
      else $error("pending decrement on an inactive slot");

   // a finishing job leaves the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && fin_done |=> !active_ff[$past(best_idx_ff)])
      else $error("finished job still marked active");

   // a completion beat is always a busy tick, never a rejected add
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_busy_ff && !rsp_err_ff)
      else $error("completion reported without a running job");

   // the RAM is never read and written at the same entry in one cycle
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("slot RAM read and write collide");

endmodule
